// ===== rtl/dfi_pkg.sv =====
// ----------------------------------------------------------------------------
// dfi_pkg
// Shared constants, types and the cosine lookup of the 1-D DCT-II / DCT-III
// unit.
// ----------------------------------------------------------------------------
package dfi_pkg;

	localparam int N              = 32;
	localparam int COEF_FRAC_BITS = 15;
	localparam int SAMPLE_W       = 24;
	localparam int VALUE_W        = 32;
	localparam int INDEX_W        = 5;
	localparam int ADDR_W         = $clog2(N);
	localparam int ROM_W          = $clog2(4 * N);
	localparam int COEF_W         = COEF_FRAC_BITS + 2;
	localparam int PROD_W         = SAMPLE_W + COEF_W;
	localparam int ACC_W          = PROD_W + ADDR_W;
	localparam int FWD_SHIFT      = COEF_FRAC_BITS - 1;
	localparam int INV_SHIFT      = ADDR_W + COEF_FRAC_BITS;

	// first quadrant of cos(pi*r/(2N)) in Q1.15, r = 0..N, unclipped
	localparam logic [COEF_FRAC_BITS:0] QCOS [0:N] = '{
		16'd32768, 16'd32729, 16'd32610, 16'd32413, 16'd32138, 16'd31786,
		16'd31357, 16'd30853, 16'd30274, 16'd29622, 16'd28899, 16'd28106,
		16'd27246, 16'd26320, 16'd25330, 16'd24279, 16'd23170, 16'd22006,
		16'd20788, 16'd19520, 16'd18205, 16'd16846, 16'd15447, 16'd14010,
		16'd12540, 16'd11039, 16'd9512,  16'd7962,  16'd6393,  16'd4808,
		16'd3212,  16'd1608,  16'd0
	};

	// weight of the dc term in the inverse transform
	localparam logic signed [COEF_W-1:0] HALF_COEF = COEF_W'(2 ** (COEF_FRAC_BITS - 1));

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} ctrl_state_t;

	typedef struct packed {
		logic                     vld;
		logic                     clr;
		logic signed [COEF_W-1:0] coef;
		logic                     emit;
		logic [ADDR_W-1:0]        idx;
		logic                     last;
		logic                     inv;
	} mac_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} mac_stat_t;

	function automatic logic signed [COEF_W-1:0] coef_lookup(input logic [ROM_W-1:0] m);
		logic [ROM_W-1:0]          r;
		logic                      neg;
		logic [COEF_FRAC_BITS:0]   mag;
		logic signed [COEF_W-1:0]  res;
		if (m <= ROM_W'(N)) begin
			r   = m;
			neg = 1'b0;
		end else if (m <= ROM_W'(2 * N)) begin
			r   = ROM_W'(2 * N) - m;
			neg = 1'b1;
		end else if (m < ROM_W'(3 * N)) begin
			r   = m - ROM_W'(2 * N);
			neg = 1'b1;
		end else begin
			r   = ROM_W'(4 * N) - m;
			neg = 1'b0;
		end
		mag = QCOS[r[ADDR_W:0]];
		if (neg) begin
			res = -$signed({1'b0, mag});
		end else if (mag > (COEF_FRAC_BITS + 1)'(2 ** COEF_FRAC_BITS - 1)) begin
			res = COEF_W'(2 ** COEF_FRAC_BITS - 1);
		end else begin
			res = $signed({1'b0, mag});
		end
		return res;
	endfunction

endpackage

// ===== rtl/dfi_sample_if.sv =====
// ----------------------------------------------------------------------------
// dfi_sample_if
// Sample request channel: valid/ready handshake with one signed sample.
// ----------------------------------------------------------------------------
interface dfi_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [dfi_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/dfi_result_if.sv =====
// ----------------------------------------------------------------------------
// dfi_result_if
// Result request channel: valid/ready handshake with one transform result.
// ----------------------------------------------------------------------------
interface dfi_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [dfi_pkg::VALUE_W-1:0] value;
	logic [dfi_pkg::INDEX_W-1:0]        index;
	logic                               last;
	logic                               saturated;

	modport source (output valid, output value, output index, output last,
		output saturated, input ready);
	modport sink   (input valid, input value, input index, input last,
		input saturated, output ready);
endinterface

// ===== rtl/dfi_ram.sv =====
// ----------------------------------------------------------------------------
// dfi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/dfi_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfi_ctrl
// Sequencer: fills the sample buffer, then walks every output index over all
// buffer entries, producing the cosine coefficient beside each buffer read.
// ----------------------------------------------------------------------------
module dfi_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       direction,
	output logic                       ram_we,
	output logic [dfi_pkg::ADDR_W-1:0] ram_waddr,
	output logic                       ram_re,
	output logic [dfi_pkg::ADDR_W-1:0] ram_raddr,
	output dfi_pkg::mac_cmd_t          cmd,
	input  dfi_pkg::mac_stat_t         stat
);

	dfi_pkg::ctrl_state_t               state_q;
	logic [dfi_pkg::ADDR_W-1:0]         load_cnt_q;
	logic [dfi_pkg::ADDR_W-1:0]         a_q;
	logic [dfi_pkg::ADDR_W-1:0]         b_q;
	logic [dfi_pkg::ROM_W-1:0]          m_q;
	logic [dfi_pkg::ROM_W-1:0]          step_q;
	logic                               inv_q;
	logic                               vld_s1;
	logic                               clr_s1;
	logic signed [dfi_pkg::COEF_W-1:0]  coef_s1;
	logic [dfi_pkg::ADDR_W-1:0]         a_nxt;
	logic                               accept;
	logic                               emit_go;
	logic                               a_last;

	always_comb begin
		in_ready  = (state_q == dfi_pkg::ST_LOAD);
		accept    = in_valid && in_ready;
		ram_we    = accept;
		ram_waddr = load_cnt_q;
		ram_re    = (state_q == dfi_pkg::ST_ISSUE);
		ram_raddr = b_q;
		a_nxt     = a_q + 1'b1;
		a_last    = (a_q == dfi_pkg::ADDR_W'(dfi_pkg::N - 1));
		emit_go   = (state_q == dfi_pkg::ST_EMIT) && stat.out_free;
	end

	always_comb begin
		cmd.vld  = vld_s1;
		cmd.clr  = clr_s1;
		cmd.coef = coef_s1;
		cmd.emit = emit_go;
		cmd.idx  = a_q;
		cmd.last = a_last;
		cmd.inv  = inv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dfi_pkg::ST_LOAD;
			load_cnt_q <= '0;
			a_q        <= '0;
			b_q        <= '0;
			m_q        <= '0;
			step_q     <= '0;
			inv_q      <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= (state_q == dfi_pkg::ST_ISSUE);
			case (state_q)
				dfi_pkg::ST_LOAD: begin
					if (accept) begin
						if (load_cnt_q == dfi_pkg::ADDR_W'(dfi_pkg::N - 1)) begin
							load_cnt_q <= '0;
							inv_q      <= direction;
							a_q        <= '0;
							b_q        <= '0;
							m_q        <= '0;
							step_q     <= dfi_pkg::ROM_W'(direction);
							state_q    <= dfi_pkg::ST_ISSUE;
						end else begin
							load_cnt_q <= load_cnt_q + 1'b1;
						end
					end
				end
				dfi_pkg::ST_ISSUE: begin
					b_q <= b_q + 1'b1;
					m_q <= m_q + step_q;
					if (b_q == dfi_pkg::ADDR_W'(dfi_pkg::N - 1)) begin
						state_q <= dfi_pkg::ST_DRAIN;
					end
				end
				dfi_pkg::ST_DRAIN: begin
					if (!vld_s1 && !stat.busy) begin
						state_q <= dfi_pkg::ST_EMIT;
					end
				end
				dfi_pkg::ST_EMIT: begin
					if (emit_go) begin
						if (a_last) begin
							state_q <= dfi_pkg::ST_LOAD;
						end else begin
							a_q     <= a_nxt;
							b_q     <= '0;
							m_q     <= inv_q ? '0 : dfi_pkg::ROM_W'(a_nxt);
							step_q  <= dfi_pkg::ROM_W'({a_nxt, inv_q});
							state_q <= dfi_pkg::ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= dfi_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// coefficient travels beside the buffer read
	always_ff @(posedge clk) begin
		clr_s1 <= (b_q == '0);
		if (inv_q && (b_q == '0)) begin
			coef_s1 <= dfi_pkg::HALF_COEF;
		end else begin
			coef_s1 <= dfi_pkg::coef_lookup(m_q);
		end
	end

endmodule

// ===== rtl/dfi_mac.sv =====
// ----------------------------------------------------------------------------
// dfi_mac
// Shared multiply-accumulate, rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module dfi_mac (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [dfi_pkg::SAMPLE_W-1:0] rdata,
	input  dfi_pkg::mac_cmd_t            cmd,
	output dfi_pkg::mac_stat_t           stat,
	dfi_result_if.source                 res
);

	localparam logic signed [dfi_pkg::ACC_W:0] FWD_BIAS =
		{{dfi_pkg::ACC_W{1'b0}}, 1'b1} << (dfi_pkg::FWD_SHIFT - 1);
	localparam logic signed [dfi_pkg::ACC_W:0] INV_BIAS =
		{{dfi_pkg::ACC_W{1'b0}}, 1'b1} << (dfi_pkg::INV_SHIFT - 1);
	localparam logic signed [dfi_pkg::ACC_W:0] VMAX =
		{{(dfi_pkg::ACC_W + 1 - dfi_pkg::VALUE_W){1'b0}}, 1'b0,
		{(dfi_pkg::VALUE_W - 1){1'b1}}};
	localparam logic signed [dfi_pkg::ACC_W:0] VMIN =
		{{(dfi_pkg::ACC_W + 1 - dfi_pkg::VALUE_W){1'b1}}, 1'b1,
		{(dfi_pkg::VALUE_W - 1){1'b0}}};

	logic                               vld_s2;
	logic                               clr_s2;
	logic signed [dfi_pkg::PROD_W-1:0]  prod_s2;
	logic signed [dfi_pkg::ACC_W-1:0]   acc_q;
	logic signed [dfi_pkg::ACC_W:0]     biased;
	logic signed [dfi_pkg::ACC_W:0]     shifted;
	logic                               over;
	logic                               under;
	logic                               out_vld_q;
	logic signed [dfi_pkg::VALUE_W-1:0] value_q;
	logic [dfi_pkg::INDEX_W-1:0]        index_q;
	logic                               last_q;
	logic                               sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= cmd.vld;
		end
	end

	always_ff @(posedge clk) begin
		clr_s2  <= cmd.clr;
		prod_s2 <= $signed(rdata) * $signed(cmd.coef);
		if (vld_s2) begin
			if (clr_s2) begin
				acc_q <= dfi_pkg::ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + dfi_pkg::ACC_W'(prod_s2);
			end
		end
	end

	// round to nearest, ties up, then clip to the output range
	always_comb begin
		biased  = {acc_q[dfi_pkg::ACC_W-1], acc_q} + (cmd.inv ? INV_BIAS : FWD_BIAS);
		shifted = cmd.inv ? (biased >>> dfi_pkg::INV_SHIFT) : (biased >>> dfi_pkg::FWD_SHIFT);
		over    = (shifted > VMAX);
		under   = (shifted < VMIN);
	end

	always_comb begin
		stat.busy     = vld_s2;
		stat.out_free = !out_vld_q || res.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (over) begin
				value_q <= VMAX[dfi_pkg::VALUE_W-1:0];
			end else if (under) begin
				value_q <= VMIN[dfi_pkg::VALUE_W-1:0];
			end else begin
				value_q <= shifted[dfi_pkg::VALUE_W-1:0];
			end
			index_q <= dfi_pkg::INDEX_W'(cmd.idx);
			last_q  <= cmd.last;
			sat_q   <= over || under;
		end
	end

	always_comb begin
		res.valid     = out_vld_q;
		res.value     = value_q;
		res.index     = index_q;
		res.last      = last_q;
		res.saturated = sat_q;
	end

endmodule

// ===== rtl/dct_forward_inverse_1d_unit.sv =====
// ----------------------------------------------------------------------------
// dct_forward_inverse_1d_unit
// 1-D direct-form DCT-II (forward) and DCT-III (inverse) over blocks of N
// samples.
//
// samples: one signed 24-bit sample per request, N requests make a block.
// results: N requests per block in index order, last set on the final one,
//   saturated set where the rounded value was clipped to 32 bits.
// direction_we/direction_wdata: 0 forward, 1 inverse; taken at the request
//   that completes a block; they must be written only while the unit is
//   idle, which the unit itself does not enforce.
// The N samples of a block are accepted one per cycle into a buffer RAM.
// After the last sample, samples.ready stays low while one shared
// multiply-accumulate reads one buffer entry per cycle: each result is
// formed by N reads, a pipeline drain and a result load.
// A stalled receiver holds the result register and the sequencer waits.
// Reset clears the sample count and direction; the buffer holds no reset
// value and is read only after a full block has been written.
// ----------------------------------------------------------------------------
module dct_forward_inverse_1d_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        direction_we,
	input  logic        direction_wdata,
	dfi_sample_if.sink   samples,
	dfi_result_if.source results
);

	logic                         direction_q;
	logic                         ram_we;
	logic [dfi_pkg::ADDR_W-1:0]   ram_waddr;
	logic                         ram_re;
	logic [dfi_pkg::ADDR_W-1:0]   ram_raddr;
	logic [dfi_pkg::SAMPLE_W-1:0] ram_rdata;
	dfi_pkg::mac_cmd_t            cmd;
	dfi_pkg::mac_stat_t           stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (direction_we) begin
			direction_q <= direction_wdata;
		end
	end

	dfi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.direction (direction_q),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.cmd       (cmd),
		.stat      (stat)
	);

	dfi_ram #(
		.WIDTH (dfi_pkg::SAMPLE_W),
		.DEPTH (dfi_pkg::N)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (samples.sample),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dfi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.rdata  (ram_rdata),
		.cmd    (cmd),
		.stat   (stat),
		.res    (results)
	);

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("buffer written while being read");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.last |-> results.index == dfi_pkg::INDEX_W'(dfi_pkg::N - 1))
		else $error("last flag on wrong index");

	a_block_closes: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_waddr == dfi_pkg::ADDR_W'(dfi_pkg::N - 1) |=> !samples.ready)
		else $error("samples still taken after a full block");

	a_emit_settled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !stat.busy && !cmd.vld)
		else $error("result taken before accumulation settled");

endmodule

// ===== tb/tb_dct_forward_inverse_1d_unit.sv =====
// ----------------------------------------------------------------------------
// tb_dct_forward_inverse_1d_unit
// Self-checking bench for the 1-D DCT-II / DCT-III unit. Blocks of samples go
// in through the sample channel. A bit-exact model of the direct-form transform
// predicts every result request, and each one that comes out of the result
// channel is checked field by field. Directed blocks cover extreme samples
// in both directions and walking-bit samples in the forward one. Random
// blocks run with random gaps on both channels, a stretch with no gaps,
// and a long output stall that backs the unit up into its sample input.
// ----------------------------------------------------------------------------
module tb_dct_forward_inverse_1d_unit;

	import dfi_pkg::*;

	localparam int ROM_SIZE        = 4 * N;
	localparam int RESET_CYCLES    = 11;
	localparam int IDLE_PCT        = 22;
	localparam int HOLD_CYCLES     = 600;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int INV_ROUND_SHIFT = $clog2(N) + COEF_FRAC_BITS + 1;

	localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [INDEX_W-1:0]        index;
		logic                      last;
		logic                      saturated;
	} dct_result_t;

	logic clk;
	logic arst_n;
	logic direction_we;
	logic direction_wdata;

	dfi_sample_if sample_ch ();
	dfi_result_if result_ch ();

	dct_forward_inverse_1d_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.direction_we    (direction_we),
		.direction_wdata (direction_wdata),
		.samples         (sample_ch),
		.results         (result_ch)
	);

	int                        cos_q15 [ROM_SIZE];
	logic signed [SAMPLE_W-1:0] block_buf [N];
	int                        fill_count;
	bit                        inverse_mode;
	dct_result_t               transform_queue [$];

	bit steady;
	bit hold_request;
	int failures;
	int results_checked;
	int forward_blocks;
	int inverse_blocks;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return p[123:60];
	endfunction

	// cosine table: taylor series in q60, rounded to q1.15, +1.0 clipped
	initial begin
		int          m;
		int          r;
		int          j;
		bit          neg;
		logic [63:0] den;
		logic [63:0] theta;
		logic [63:0] t2;
		logic [63:0] acc;
		logic [63:0] term;
		logic [63:0] mag;
		den = 64'(2 * N);
		for (m = 0; m < ROM_SIZE; m++) begin
			if (m <= N) begin
				r   = m;
				neg = 1'b0;
			end else if (m <= 2 * N) begin
				r   = 2 * N - m;
				neg = 1'b1;
			end else if (m < 3 * N) begin
				r   = m - 2 * N;
				neg = 1'b1;
			end else begin
				r   = 4 * N - m;
				neg = 1'b0;
			end
			theta = (PI_Q60 / den) * 64'(r) + ((PI_Q60 % den) * 64'(r)) / den;
			t2    = q60_product(theta, theta);
			acc   = ONE_Q60;
			term  = ONE_Q60;
			for (j = 1; j <= 16; j++) begin
				term = q60_product(term, t2) / 64'((2 * j - 1) * (2 * j));
				if (j % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			mag = (acc + (64'd1 << (59 - COEF_FRAC_BITS))) >> (60 - COEF_FRAC_BITS);
			if (neg) begin
				if (mag > (64'd1 << COEF_FRAC_BITS)) begin
					mag = 64'd1 << COEF_FRAC_BITS;
				end
				cos_q15[m] = -int'(mag);
			end else begin
				if (mag > (64'd1 << COEF_FRAC_BITS) - 64'd1) begin
					mag = (64'd1 << COEF_FRAC_BITS) - 64'd1;
				end
				cos_q15[m] = int'(mag);
			end
		end
	end

	// full block in buffer: queue all N transform outputs in index order
	function automatic void predict_block();
		int          a;
		int          b;
		longint      acc;
		longint      v;
		dct_result_t res;
		for (a = 0; a < N; a++) begin
			if (!inverse_mode) begin
				acc = 0;
				for (b = 0; b < N; b++) begin
					acc += longint'(block_buf[b]) * longint'(cos_q15[(a * (2 * b + 1)) % ROM_SIZE]);
				end
				v = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 2))) >>> (COEF_FRAC_BITS - 1);
			end else begin
				acc = longint'(block_buf[0]) * (longint'(1) <<< (COEF_FRAC_BITS - 1));
				for (b = 1; b < N; b++) begin
					acc += longint'(block_buf[b]) * longint'(cos_q15[(b * (2 * a + 1)) % ROM_SIZE]);
				end
				v = (2 * acc + (longint'(N) <<< COEF_FRAC_BITS)) >>> INV_ROUND_SHIFT;
			end
			res.saturated = 1'b0;
			if (v > 64'sd2147483647) begin
				v             = 64'sd2147483647;
				res.saturated = 1'b1;
			end
			if (v < -64'sd2147483648) begin
				v             = -64'sd2147483648;
				res.saturated = 1'b1;
			end
			res.value = v[VALUE_W-1:0];
			res.index = INDEX_W'(a);
			res.last  = (a == N - 1);
			transform_queue.push_back(res);
		end
		if (inverse_mode) begin
			inverse_blocks++;
		end else begin
			forward_blocks++;
		end
	endfunction

	always @(posedge clk) begin : channel_monitor
		dct_result_t exp;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (transform_queue.size() == 0) begin
				$error("unexpected result request, index %0d value %0d",
					result_ch.index, result_ch.value);
				failures++;
			end else begin
				exp = transform_queue.pop_front();
				results_checked++;
				if (result_ch.value !== exp.value) begin
					$error("value: expected %0d, got %0d", exp.value, result_ch.value);
					failures++;
				end
				if (result_ch.index !== exp.index) begin
					$error("index: expected %0d, got %0d", exp.index, result_ch.index);
					failures++;
				end
				if (result_ch.last !== exp.last) begin
					$error("last: expected %0b, got %0b", exp.last, result_ch.last);
					failures++;
				end
				if (result_ch.saturated !== exp.saturated) begin
					$error("saturated: expected %0b, got %0b", exp.saturated,
						result_ch.saturated);
					failures++;
				end
			end
		end
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			block_buf[fill_count] = sample_ch.sample;
			fill_count++;
			if (fill_count == N) begin
				fill_count = 0;
				predict_block();
			end
		end
	end

	// result receiver, with the long hold-off counted here
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("no request moved for %0d cycles", WATCHDOG_LIMIT);
		$display("dct_forward_inverse_1d_unit verification failed");
		$finish;
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(0, 99) < IDLE_PCT);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		@(posedge clk);
		while (!sample_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// first let the monitor queue the block just completed
	task automatic await_results();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (transform_queue.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_direction(input bit inv);
		await_results();
		repeat (4) @(posedge clk);
		direction_we    <= 1'b1;
		direction_wdata <= inv;
		@(posedge clk);
		direction_we <= 1'b0;
		inverse_mode = inv;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 3))
			0: begin
				return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			end
			1: begin
				return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
			end
			default: begin
				return SAMPLE_W'($urandom);
			end
		endcase
	endfunction

	task automatic send_random_blocks(input int count);
		int i;
		for (i = 0; i < count * N; i++) begin
			send_sample(random_sample());
		end
	endtask

	// extremes, small values and a walking one through every sample bit
	task automatic test_forward_extremes();
		int                         i;
		logic signed [SAMPLE_W-1:0] s;
		set_direction(1'b0);
		for (i = 0; i < N; i++) begin
			case (i)
				0, 5, 7: s = SAMPLE_MAX;
				1, 6:    s = SAMPLE_MIN;
				2:       s = '0;
				3:       s = '1;
				4:       s = SAMPLE_W'(1);
				default: s = SAMPLE_W'(1) << (i - 8);
			endcase
			send_sample(s);
		end
	endtask

	// highest and lowest frequency content at full scale
	task automatic test_inverse_extremes();
		int i;
		set_direction(1'b1);
		for (i = 0; i < N; i++) begin
			send_sample((i % 2 == 1) ? SAMPLE_MIN : SAMPLE_MAX);
		end
	endtask

	task automatic test_steady_stream();
		set_direction(1'b0);
		steady = 1'b1;
		send_random_blocks(1);
		await_results();
		steady = 1'b0;
	endtask

	// receiver stalls while a second block is offered behind the first
	task automatic test_output_backpressure();
		set_direction(1'b1);
		hold_request = 1'b1;
		send_random_blocks(2);
	endtask

	initial begin
		arst_n           <= 1'b0;
		direction_we     <= 1'b0;
		direction_wdata  <= 1'b0;
		sample_ch.valid  <= 1'b0;
		sample_ch.sample <= '0;
		fill_count      = 0;
		inverse_mode    = 1'b0;
		steady          = 1'b0;
		hold_request    = 1'b0;
		failures        = 0;
		results_checked = 0;
		forward_blocks  = 0;
		inverse_blocks  = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_forward_extremes();
		test_inverse_extremes();
		test_steady_stream();
		test_output_backpressure();

		await_results();
		repeat (2 * N) @(posedge clk);
		$display("checked %0d results from %0d forward and %0d inverse blocks",
			results_checked, forward_blocks, inverse_blocks);
		$display("with random gaps, a gap-free block and a %0d-cycle output stall",
			HOLD_CYCLES);
		if (failures == 0) begin
			$display("dct_forward_inverse_1d_unit verification clean");
		end else begin
			$display("dct_forward_inverse_1d_unit verification failed");
		end
		$finish;
	end

endmodule
